// ----- hw/rtl/sfla_pkg.sv -----
// Shared constants, types and codes for the slab free-list allocator.
package sfla_pkg;

  localparam int MAX_OBJECTS  = 256;
  localparam int HEADER_BYTES = 16;
  localparam int INDEX_BYTES  = 2;

  localparam int PAGE_W  = 20;
  localparam int OBJ_W   = 16;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = $clog2(MAX_OBJECTS + 1);
  localparam int IDX_W   = $clog2(MAX_OBJECTS);
  localparam int DVS_W   = OBJ_W + 1;
  localparam int STEP_W  = $clog2(PAGE_W + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [PAGE_W-1:0] PAGE_RST = PAGE_W'(4096);
  localparam logic [OBJ_W-1:0]  OBJ_RST  = OBJ_W'(64);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INIT  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SMALL = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_BYTES   = 1'd0,
    CFG_OBJECT_BYTES = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_FILL,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/slab_free_list_allocator_core.sv -----
// Top level of the slab free-list allocator: request sequencer, serial divider and multiplier.
//
// One request is taken at a time; the next may be taken while the previous answer still
// waits in the output register. An allocation works one multiplier bit per cycle over the
// 9-bit head index; a free works one quotient bit per cycle over the 20-bit dividend; an
// init runs that division and then writes one table entry per cycle through the single
// RAM write port. Requests answered from a check alone (exhausted list, offset below the
// object region, page smaller than the header, unused request code) go straight from idle
// to the answer state. The link table is a 256 x 9 RAM with no clearing pass: init writes
// every entry that can later be read.
// page_bytes and object_bytes are sampled only by an init request; write them while idle.
module slab_free_list_allocator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sfla_pkg::REQ_W-1:0]          in_req_type,
  input  logic [sfla_pkg::PAGE_W-1:0]         in_free_offset,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sfla_pkg::STAT_W-1:0]         out_status,
  output logic [sfla_pkg::PAGE_W-1:0]         out_object_offset,
  output logic [sfla_pkg::CNT_W-1:0]          out_object_total,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfla_pkg::PAGE_W-1:0]         cfg_data
);

  import sfla_pkg::*;

  // sequencer and datapath registers
  state_t              state_r, state_nxt;
  req_t                op_r, op_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [PAGE_W-1:0]   quo_r, quo_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [PAGE_W-1:0]   acc_r, acc_nxt;
  logic [PAGE_W-1:0]   mcand_r, mcand_nxt;
  logic [CNT_W-1:0]    mplr_r, mplr_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;

  // allocator state
  logic [CNT_W-1:0]    free_head_r, free_head_nxt;
  logic [CNT_W-1:0]    object_count_r, object_count_nxt;
  logic [PAGE_W-1:0]   region_start_r, region_start_nxt;
  logic [OBJ_W-1:0]    held_size_r, held_size_nxt;

  // configuration
  logic [PAGE_W-1:0]   page_bytes_r;
  logic [OBJ_W-1:0]    object_bytes_r;

  // pending answer and output register
  status_t             res_status_r, res_status_nxt;
  logic [PAGE_W-1:0]   res_offset_r, res_offset_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]   out_offset_r, out_offset_nxt;
  logic [CNT_W-1:0]    out_total_r, out_total_nxt;

  // link table port
  logic                ram_we;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [CNT_W-1:0]    ram_wr_data;
  logic [CNT_W-1:0]    ram_rd_data;

  // step logic
  logic                in_xfer;
  logic                out_xfer;
  req_t                in_req;
  logic [DVS_W:0]      div_trial;
  logic                div_ge;
  logic [DVS_W-1:0]    div_rem_step;
  logic [PAGE_W-1:0]   div_quo_step;
  logic [PAGE_W-1:0]   mul_acc_step;
  logic [CNT_W-1:0]    init_count;
  logic [OBJ_W-1:0]    init_size;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_req   = req_t'(in_req_type);

  // One restoring-division step: bring in the next dividend bit, subtract if it fits.
  assign div_trial    = {rem_r, quo_r[PAGE_W-1]};
  assign div_ge       = (div_trial >= {1'b0, dvs_r});
  assign div_rem_step = div_ge ? DVS_W'(div_trial - {1'b0, dvs_r}) : div_trial[DVS_W-1:0];
  assign div_quo_step = {quo_r[PAGE_W-2:0], div_ge};

  // One shift-add multiply step, least significant multiplier bit first.
  assign mul_acc_step = mplr_r[0] ? PAGE_W'(acc_r + mcand_r) : acc_r;

  // Cap the object count at the table depth.
  assign init_count = (div_quo_step >= PAGE_W'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS)
                                                             : div_quo_step[CNT_W-1:0];
  // A zero object size counts as one byte.
  assign init_size  = (object_bytes_r == '0) ? OBJ_W'(1) : object_bytes_r;

  sfla_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_OBJECTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (free_head_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Configuration registers: the user must write them only while idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r   <= PAGE_RST;
      object_bytes_r <= OBJ_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PAGE_BYTES:   page_bytes_r   <= cfg_data;
        CFG_OBJECT_BYTES: object_bytes_r <= cfg_data[OBJ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      free_head_r    <= '0;
      object_count_r <= '0;
      region_start_r <= '0;
      held_size_r    <= OBJ_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      free_head_r    <= free_head_nxt;
      object_count_r <= object_count_nxt;
      region_start_r <= region_start_nxt;
      held_size_r    <= held_size_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Datapath and answer payload: no reset needed.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    step_r       <= step_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dvs_r        <= dvs_nxt;
    acc_r        <= acc_nxt;
    mcand_r      <= mcand_nxt;
    mplr_r       <= mplr_nxt;
    fill_r       <= fill_nxt;
    res_status_r <= res_status_nxt;
    res_offset_r <= res_offset_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_total_r  <= out_total_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    step_nxt         = step_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    dvs_nxt          = dvs_r;
    acc_nxt          = acc_r;
    mcand_nxt        = mcand_r;
    mplr_nxt         = mplr_r;
    fill_nxt         = fill_r;
    free_head_nxt    = free_head_r;
    object_count_nxt = object_count_r;
    region_start_nxt = region_start_r;
    held_size_nxt    = held_size_r;
    res_status_nxt   = res_status_r;
    res_offset_nxt   = res_offset_r;
    out_status_nxt   = out_status_r;
    out_offset_nxt   = out_offset_r;
    out_total_nxt    = out_total_r;
    ram_we           = 1'b0;
    ram_wr_addr      = fill_r[IDX_W-1:0];
    ram_wr_data      = CNT_W'(fill_r + CNT_W'(1));

    // drop the output once it has been transferred
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_req;
          step_nxt       = '0;
          rem_nxt        = '0;
          res_status_nxt = ST_OK;
          res_offset_nxt = '0;
          state_nxt      = S_DONE;
          unique case (in_req)
            REQ_ALLOC: begin
              if (free_head_r >= object_count_r) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                acc_nxt   = '0;
                mcand_nxt = PAGE_W'(held_size_r);
                mplr_nxt  = free_head_r;
                state_nxt = S_MUL;
              end
            end
            REQ_FREE: begin
              if (in_free_offset < region_start_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                quo_nxt   = PAGE_W'(in_free_offset - region_start_r);
                dvs_nxt   = DVS_W'(held_size_r);
                state_nxt = S_DIV;
              end
            end
            REQ_INIT: begin
              held_size_nxt = init_size;
              if (page_bytes_r < PAGE_W'(HEADER_BYTES)) begin
                res_status_nxt   = ST_SMALL;
                object_count_nxt = '0;
              end else begin
                quo_nxt   = PAGE_W'(page_bytes_r - PAGE_W'(HEADER_BYTES));
                dvs_nxt   = DVS_W'(DVS_W'(init_size) + DVS_W'(INDEX_BYTES));
                state_nxt = S_DIV;
              end
            end
            REQ_NOP: ;
            default: ;
          endcase
        end
      end

      S_DIV: begin
        rem_nxt  = div_rem_step;
        quo_nxt  = div_quo_step;
        step_nxt = STEP_W'(step_r + STEP_W'(1));
        if (step_r == STEP_W'(PAGE_W - 1)) begin
          state_nxt = S_DONE;
          if (op_r == REQ_INIT) begin
            if (init_count == '0) begin
              res_status_nxt   = ST_SMALL;
              object_count_nxt = '0;
            end else begin
              object_count_nxt = init_count;
              region_start_nxt = PAGE_W'(PAGE_W'(HEADER_BYTES) +
                                         PAGE_W'(init_count) * PAGE_W'(INDEX_BYTES));
              free_head_nxt    = '0;
              fill_nxt         = '0;
              state_nxt        = S_FILL;
            end
          end else begin
            // free: the quotient is the object index
            if (div_quo_step >= PAGE_W'(object_count_r)) begin
              res_status_nxt = ST_RANGE;
            end else begin
              ram_we        = 1'b1;
              ram_wr_addr   = div_quo_step[IDX_W-1:0];
              ram_wr_data   = free_head_r;
              free_head_nxt = div_quo_step[CNT_W-1:0];
            end
          end
        end
      end

      S_MUL: begin
        acc_nxt   = mul_acc_step;
        mcand_nxt = {mcand_r[PAGE_W-2:0], 1'b0};
        mplr_nxt  = {1'b0, mplr_r[CNT_W-1:1]};
        step_nxt  = STEP_W'(step_r + STEP_W'(1));
        if (step_r == STEP_W'(CNT_W - 1)) begin
          // link table has been reading the head entry throughout
          res_offset_nxt = PAGE_W'(region_start_r + mul_acc_step);
          free_head_nxt  = ram_rd_data;
          state_nxt      = S_DONE;
        end
      end

      S_FILL: begin
        // link entry i to i+1, one entry per cycle
        ram_we   = 1'b1;
        fill_nxt = CNT_W'(fill_r + CNT_W'(1));
        if (fill_r == CNT_W'(object_count_r - CNT_W'(1))) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // hold the answer until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_offset_nxt = res_offset_r;
          out_total_nxt  = object_count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_object_offset = out_offset_r;
  assign out_object_total  = out_total_r;

  // An accepted request always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // The object count never exceeds the table depth.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    object_count_r <= CNT_W'(MAX_OBJECTS))
    else $error("object count above table depth");

  // The table is written only by the fill sweep or at the end of a free.
  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_FILL) || ((state_r == S_DIV) && (op_r == REQ_FREE))))
    else $error("link table written outside fill or free");

  // The fill sweep stays inside the object count.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (fill_r < object_count_r))
    else $error("fill sweep ran past object count");

  // A finished answer, once released, is registered into the output register with valid set.
  a_answer_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (state_nxt == S_IDLE)) |=> out_valid_r)
    else $error("answer released without output valid");

endmodule

// ----- hw/rtl/sfla_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sim/slab_free_list_allocator_core_test.sv -----
// Self-checking bench for the slab free-list allocator core: directed cases, then random phases.
module slab_free_list_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfla_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 900000;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned PAGE_MAX     = (1 << PAGE_W) - 1;
  localparam int unsigned OBJ_MAX      = (1 << OBJ_W) - 1;

  typedef struct packed {
    req_t              kind;
    logic [PAGE_W-1:0] offset;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] offset;
    logic [CNT_W-1:0]  total;
  } answer_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  req_t              in_req_type    = REQ_NOP;
  logic [PAGE_W-1:0] in_free_offset = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [PAGE_W-1:0] out_object_offset;
  logic [CNT_W-1:0]  out_object_total;
  logic              cfg_wr_en      = 1'b0;
  cfg_reg_t          cfg_index      = CFG_PAGE_BYTES;
  logic [PAGE_W-1:0] cfg_data       = '0;

  slab_free_list_allocator_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_free_offset    (in_free_offset),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_object_offset (out_object_offset),
    .out_object_total  (out_object_total),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be driven, and answers owed by the block in transfer order.
  request_t pending_reqs[$];
  answer_t  answers_due[$];

  // Register contents as the block holds them; the block only looks at them on init.
  int unsigned page_cfg = PAGE_RST;
  int unsigned obj_cfg  = OBJ_RST;

  // Allocator state as it should stand after every accepted request.
  logic [CNT_W-1:0] link_tab [MAX_OBJECTS];
  int unsigned head_idx    = 0;
  int unsigned live_count  = 0;
  int unsigned region_base = 0;
  int unsigned live_size   = OBJ_RST;

  // Same layout, tracked at planning time so that random frees can aim at real objects.
  int unsigned plan_count  = 0;
  int unsigned plan_region = 0;
  int unsigned plan_size   = OBJ_RST;

  int unsigned cycle_count = 0;
  int unsigned bad_count   = 0;
  bit          req_taken   = 1'b0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned stall_span  = 0;
  stall_mode_t stall_mode  = STALL_NONE;

  // A zero object size is handled as one byte.
  function automatic int unsigned object_size_used(int unsigned raw);
    return (raw == 0) ? 1 : raw;
  endfunction

  // Objects that fit behind the header, each with its link entry; capped at the table size.
  function automatic int unsigned objects_in_page(int unsigned page, int unsigned size);
    int unsigned n;
    if (page < HEADER_BYTES) return 0;
    n = (page - HEADER_BYTES) / (size + INDEX_BYTES);
    return (n > MAX_OBJECTS) ? MAX_OBJECTS : n;
  endfunction

  // Advance the allocator state by one request and work out the answer it owes.
  task automatic apply_request(input req_t kind, input int unsigned offset, output answer_t ans);
    int unsigned n;
    int unsigned slot;
    ans = '0;
    ans.status = ST_OK;
    case (kind)
      REQ_INIT: begin
        live_size  = object_size_used(obj_cfg);
        n          = objects_in_page(page_cfg, live_size);
        live_count = n;
        if (n == 0) begin
          // page too small: count drops to zero, layout and head stay as they were
          ans.status = ST_SMALL;
        end else begin
          region_base = HEADER_BYTES + n * INDEX_BYTES;
          head_idx    = 0;
          for (int i = 0; i < n; i++) link_tab[i] = CNT_W'(i + 1);
        end
      end
      REQ_ALLOC: begin
        if (head_idx >= live_count) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.offset = PAGE_W'(region_base + head_idx * live_size);
          head_idx   = 32'(link_tab[head_idx]);
        end
      end
      REQ_FREE: begin
        if (offset < region_base) begin
          ans.status = ST_RANGE;
        end else begin
          // an offset inside an object truncates to that object; double frees go through
          slot = (offset - region_base) / live_size;
          if (slot >= live_count) begin
            ans.status = ST_RANGE;
          end else begin
            link_tab[slot] = CNT_W'(head_idx);
            head_idx       = slot;
          end
        end
      end
      default: ;
    endcase
    ans.total = CNT_W'(live_count);
  endtask

  // Queue one request for the driver and keep the planning view of the layout current.
  task automatic plan_request(input req_t kind, input int unsigned offset);
    request_t r;
    if (kind == REQ_INIT) begin
      plan_size  = object_size_used(obj_cfg);
      plan_count = objects_in_page(page_cfg, plan_size);
      if (plan_count != 0) plan_region = HEADER_BYTES + plan_count * INDEX_BYTES;
    end
    r.kind   = kind;
    r.offset = PAGE_W'(offset);
    pending_reqs.push_back(r);
  endtask

  // Mostly allocations and frees of real objects, with some stray frees, inits and no-ops.
  task automatic plan_random_request();
    int unsigned pick;
    int unsigned slot;
    pick = $urandom_range(99, 0);
    if (pick < 48) begin
      plan_request(REQ_ALLOC, $urandom_range(PAGE_MAX, 0));
    end else if (pick < 80 && plan_count != 0) begin
      slot = $urandom_range(plan_count - 1, 0);
      plan_request(REQ_FREE, plan_region + slot * plan_size +
                   ($urandom_range(1, 0) ? 0 : $urandom_range(plan_size - 1, 0)));
    end else if (pick < 90) begin
      case ($urandom_range(3, 0))
        0:       plan_request(REQ_FREE, $urandom_range(PAGE_MAX, 0));
        1:       plan_request(REQ_FREE, plan_region - 1);
        2:       plan_request(REQ_FREE, plan_region + plan_count * plan_size +
                                        $urandom_range(plan_size - 1, 0));
        default: plan_request(REQ_FREE, $urandom_range(plan_region, 0));
      endcase
    end else if (pick < 95) begin
      plan_request(REQ_INIT, $urandom_range(PAGE_MAX, 0));
    end else begin
      plan_request(REQ_NOP, $urandom_range(PAGE_MAX, 0));
    end
  endtask

  // Hold until nothing is queued, nothing is offered and every answer has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || answers_due.size() != 0);
  endtask

  // Write both registers while the block is idle; the top bits above object_bytes are noise.
  task automatic write_config(input int unsigned page, input int unsigned obj);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PAGE_BYTES;
    cfg_data  <= PAGE_W'(page);
    page_cfg   = page & PAGE_MAX;
    @(negedge clk);
    cfg_index <= CFG_OBJECT_BYTES;
    cfg_data  <= PAGE_W'(($urandom() << OBJ_W) | (obj & OBJ_MAX));
    obj_cfg    = obj & OBJ_MAX;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Request driver: bursts of transfers with random gaps; the offered payload holds while stalled.
  // Also drives the result-side stall from a pattern that switches mode now and then.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (rst_n && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        in_valid       <= 1'b1;
        in_req_type    <= nxt.kind;
        in_free_offset <= nxt.offset;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(8, 1);
          case ($urandom_range(3, 0))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(4, 1);
            default: gap_left = $urandom_range(80, 5);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end

    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(3, 0));
      stall_span = $urandom_range(300, 20);
    end
    stall_span--;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_COIN:     out_stall <= 1'($urandom_range(1, 0));
      STALL_PERIODIC: out_stall <= ((cycle_count % 9) < 4);
      default:        out_stall <= ($urandom_range(7, 0) != 0);
    endcase
  end

  // Monitor: check each result transfer against the oldest answer owed, then predict
  // the answer for any request transfer taken at this edge.
  always @(posedge clk) begin : watch_transfers
    answer_t due;
    answer_t fresh;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_MAX)
            $display("unexpected result: status %0d offset 0x%05h total %0d",
                     out_status, out_object_offset, out_object_total);
        end else begin
          due = answers_due.pop_front();
          if (out_status !== due.status || out_object_offset !== due.offset ||
              out_object_total !== due.total) begin
            bad_count++;
            if (bad_count <= REPORT_MAX)
              $display("mismatch: expected status %0d offset 0x%05h total %0d, got %0d 0x%05h %0d",
                       due.status, due.offset, due.total,
                       out_status, out_object_offset, out_object_total);
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_req_type, 32'(in_free_offset), fresh);
        answers_due.push_back(fresh);
        req_taken = 1'b1;
      end
    end
  end

  initial begin : run_test
    int unsigned page;
    int unsigned obj;
    int unsigned n;
    int unsigned random_done;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset layout: nothing to hand out until the first init, which then uses the reset settings.
    plan_request(REQ_ALLOC, 0);
    plan_request(REQ_FREE, 0);
    plan_request(REQ_NOP, PAGE_MAX);
    plan_request(REQ_INIT, 0);
    plan_request(REQ_ALLOC, 0);
    plan_request(REQ_ALLOC, PAGE_MAX);
    plan_request(REQ_FREE, plan_region + plan_size + 5);          // inside object one
    plan_request(REQ_FREE, plan_region - 1);                      // just below the region
    plan_request(REQ_FREE, plan_region + plan_count * plan_size); // one past the last object
    plan_request(REQ_ALLOC, 0);

    // Zero object size, three objects: drain the list, then free one object twice.
    write_config(HEADER_BYTES + 3 * (1 + INDEX_BYTES), 0);
    plan_request(REQ_INIT, 0);
    repeat (4) plan_request(REQ_ALLOC, 0);
    plan_request(REQ_FREE, plan_region + 1);
    plan_request(REQ_FREE, plan_region + 1);
    repeat (2) plan_request(REQ_ALLOC, 0);

    // Largest page with the smallest objects hits the table cap.
    write_config(PAGE_MAX, 1);
    plan_request(REQ_INIT, PAGE_MAX);
    plan_request(REQ_ALLOC, 0);

    // Empty page, then a page one byte past the header with the largest objects.
    write_config(0, OBJ_MAX);
    plan_request(REQ_INIT, 0);
    plan_request(REQ_ALLOC, 0);
    plan_request(REQ_FREE, PAGE_MAX);
    write_config(HEADER_BYTES + 1, OBJ_MAX);
    plan_request(REQ_INIT, 0);

    // Random phases: new settings each time, usually an init first, mostly small pages.
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4, 5: begin
          obj  = ($urandom_range(3, 0) == 0) ? $urandom_range(OBJ_MAX, 0)
                                             : $urandom_range(64, 0);
          n    = $urandom_range(24, 1);
          page = HEADER_BYTES + n * (object_size_used(obj) + INDEX_BYTES) +
                 $urandom_range(object_size_used(obj) + 1, 0);
          if (page > PAGE_MAX) page = PAGE_MAX;
        end
        6: begin
          page = $urandom_range(PAGE_MAX, 0);
          obj  = $urandom_range(OBJ_MAX, 0);
        end
        7: begin
          page = PAGE_MAX;
          obj  = $urandom_range(3, 0);
        end
        8: begin
          page = $urandom_range(HEADER_BYTES + 1, 0);
          obj  = $urandom_range(OBJ_MAX, 0);
        end
        default: begin
          page = $urandom_range(4000, HEADER_BYTES);
          obj  = $urandom_range(200, 1);
        end
      endcase
      write_config(page, obj);
      n = $urandom_range(60, 15);
      if ($urandom_range(9, 0) != 0) plan_request(REQ_INIT, $urandom_range(PAGE_MAX, 0));
      repeat (n) plan_random_request();
      random_done += n + 1;
    end

    // Drain, then leave room for any stray result before the verdict.
    wait_idle();
    repeat (300) @(posedge clk);
    if (bad_count == 0 && answers_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
